@@ hw/rtl/gtg_pkg.sv @@
// gtg_pkg: widths, register codes, arctangent constants and the cell data type
// shared by the go-to-goal controller modules; depends on nothing
package gtg_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ROM_SIZE     = 24;
  localparam int SQRT_STEPS        = 17;

  localparam int POS_W  = 16;
  localparam int DIFF_W = 17;
  localparam int HEAD_W = 15;
  localparam int ERR_W  = 17;
  localparam int SPD_W  = 15;
  localparam int ANG_W  = 16;
  localparam int GAIN_W = 16;
  localparam int TOL_W  = 15;
  localparam int SQ_W   = 34;
  localparam int ROOT_W = 17;
  localparam int XY_W   = 32;
  localparam int Z_W    = 34;
  localparam int PRE_SHIFT = 12;
  localparam int Z_SHIFT   = 18;
  localparam int LIN_SHIFT = 14;
  localparam int ANG_SHIFT = 13;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIN_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd4;

  localparam logic [TOL_W-1:0]  TOL_RST       = 15'd205;
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST  = 16'd11821;
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 16'd15645;
  localparam logic [SPD_W-1:0]  MIN_SPEED_RST = 15'd614;
  localparam logic [SPD_W-1:0]  MAX_SPEED_RST = 15'd16384;

  localparam logic signed [ERR_W-1:0] ANGLE_PI     = 17'sd12868;
  localparam logic signed [ERR_W-1:0] ANGLE_TWO_PI = 17'sd25736;
  localparam logic signed [ERR_W+GAIN_W:0] ANG_LIMIT = 34'sd24576;

  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic [SQ_W-1:0]          rem;
    logic [SQ_W-1:0]          root;
    logic signed [HEAD_W-1:0] heading;
    logic                     zero_vec;
    logic                     arrived;
  } cell_data_t;

  // atan(2^-i) in radians, Q.30
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/gtg_cell.sv @@
// gtg_cell: one chain cell, a cordic micro-rotation (IDX < CORDIC_STAGES)
// and a square root step (IDX < SQRT_STEPS); own valid/ready; uses gtg_pkg
module gtg_cell import gtg_pkg::*; #(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  cell_data_t up_data,
  output logic       up_ready,
  output logic       dn_valid,
  output cell_data_t dn_data,
  input  logic       dn_ready
);

  localparam int SQ_POS = (IDX < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - IDX) : 0;
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << SQ_POS;
  localparam logic signed [Z_W-1:0] ATAN = atan_q30(IDX);

  logic                   vld_r;
  cell_data_t             data_r;
  cell_data_t             data_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic [SQ_W-1:0]        trial;

  always_comb begin
    data_nxt = up_data;
    xs = up_data.x >>> IDX;
    ys = up_data.y >>> IDX;
    trial = up_data.root + SQ_BIT;
    if (IDX < CORDIC_STAGES) begin
      if (up_data.y > 0) begin
        data_nxt.x = up_data.x + ys;
        data_nxt.y = up_data.y - xs;
        data_nxt.z = up_data.z + ATAN;
      end else begin
        data_nxt.x = up_data.x - ys;
        data_nxt.y = up_data.y + xs;
        data_nxt.z = up_data.z - ATAN;
      end
    end
    if (IDX < SQRT_STEPS) begin
      if (up_data.rem >= trial) begin
        data_nxt.rem  = up_data.rem - trial;
        data_nxt.root = (up_data.root >> 1) + SQ_BIT;
      end else begin
        data_nxt.root = up_data.root >> 1;
      end
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ hw/rtl/go_to_goal_p_controller_unit.sv @@
// go_to_goal_p_controller_unit: top level of the proportional go-to-goal controller
// front stages, a chain of gtg_cell, back stages and the result register
// depends on gtg_pkg and gtg_cell
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    pose x, y, heading, goal x, y
//   out      output     out_valid/out_ready  linear and angular speed, arrived, last
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item enters per cycle while in_ready is high; the chain is CHAIN_LEN cells, the
// larger of CORDIC_STAGES and the 17 root digits; an item that arrives gives two
// results, its command and then the stop item; each stage stalls only when full and
// its successor is stalled, the result register also while a stop item is pending;
// synchronous active-low reset empties every stage and loads register defaults
module go_to_goal_p_controller_unit import gtg_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POS_W-1:0]  in_pose_x,
  input  logic signed [POS_W-1:0]  in_pose_y,
  input  logic signed [HEAD_W-1:0] in_pose_heading,
  input  logic signed [POS_W-1:0]  in_goal_x,
  input  logic signed [POS_W-1:0]  in_goal_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SPD_W-1:0]         out_linear_speed,
  output logic signed [ANG_W-1:0]  out_angular_speed,
  output logic                     out_arrived,
  output logic                     out_last,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int CHAIN_LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int LINP_W = ROOT_W + GAIN_W;
  localparam int LINQ_W = LINP_W + 1 - LIN_SHIFT;
  localparam int ANGP_W = ERR_W + GAIN_W + 1;
  localparam logic signed [Z_W-1:0] ATAN0 = atan_q30(0);
  localparam logic signed [Z_W-1:0] Z_RND = Z_W'(1) << (Z_SHIFT - 1);
  localparam logic [LINP_W:0] LIN_RND = (LINP_W + 1)'(1) << (LIN_SHIFT - 1);
  localparam logic signed [ANGP_W-1:0] ANG_RND = ANGP_W'(1) << (ANG_SHIFT - 1);

  // configuration registers
  logic [TOL_W-1:0]    tol_r;
  logic [GAIN_W-1:0]   lin_gain_r;
  logic [GAIN_W-1:0]   ang_gain_r;
  logic [SPD_W-1:0]    min_spd_r;
  logic [SPD_W-1:0]    max_spd_r;
  logic [2*TOL_W-1:0]  tol_sq_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= TOL_RST;
      lin_gain_r <= LIN_GAIN_RST;
      ang_gain_r <= ANG_GAIN_RST;
      min_spd_r  <= MIN_SPEED_RST;
      max_spd_r  <= MAX_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOL:       tol_r      <= cfg_data[TOL_W-1:0];
        CFG_LIN_GAIN:  lin_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_ANG_GAIN:  ang_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_MIN_SPEED: min_spd_r  <= cfg_data[SPD_W-1:0];
        CFG_MAX_SPEED: max_spd_r  <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tol_sq_r <= tol_r * tol_r;
  end

  // front stage 1: differences
  logic                     f1_vld_r;
  logic                     f1_rdy;
  logic signed [DIFF_W-1:0] f1_dx_r;
  logic signed [DIFF_W-1:0] f1_dy_r;
  logic signed [HEAD_W-1:0] f1_hd_r;
  logic                     f2_rdy;

  assign f1_rdy   = !f1_vld_r || f2_rdy;
  assign in_ready = f1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (f1_rdy) begin
      f1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && in_valid) begin
      f1_dx_r <= DIFF_W'(in_goal_x) - DIFF_W'(in_pose_x);
      f1_dy_r <= DIFF_W'(in_goal_y) - DIFF_W'(in_pose_y);
      f1_hd_r <= in_pose_heading;
    end
  end

  // front stage 2: squares and quadrant pre-rotation
  logic                     f2_vld_r;
  logic [SQ_W-1:0]          f2_dxsq_r;
  logic [SQ_W-1:0]          f2_dysq_r;
  logic signed [XY_W-1:0]   f2_x_r;
  logic signed [XY_W-1:0]   f2_y_r;
  logic signed [Z_W-1:0]    f2_z_r;
  logic                     f2_zero_r;
  logic signed [HEAD_W-1:0] f2_hd_r;
  logic signed [XY_W-1:0]   x0;
  logic signed [XY_W-1:0]   y0;
  logic signed [XY_W-1:0]   x_pre;
  logic signed [XY_W-1:0]   y_pre;
  logic signed [Z_W-1:0]    z_pre;
  logic                     f3_rdy;

  assign x0 = {{(XY_W-DIFF_W-PRE_SHIFT){f1_dx_r[DIFF_W-1]}}, f1_dx_r, {PRE_SHIFT{1'b0}}};
  assign y0 = {{(XY_W-DIFF_W-PRE_SHIFT){f1_dy_r[DIFF_W-1]}}, f1_dy_r, {PRE_SHIFT{1'b0}}};

  always_comb begin
    x_pre = x0;
    y_pre = y0;
    z_pre = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_pre = y0;
        y_pre = -x0;
        z_pre = ATAN0 <<< 1;
      end else begin
        x_pre = -y0;
        y_pre = x0;
        z_pre = -(ATAN0 <<< 1);
      end
    end
  end

  assign f2_rdy = !f2_vld_r || f3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else if (f2_rdy) begin
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f2_rdy && f1_vld_r) begin
      f2_dxsq_r <= SQ_W'(f1_dx_r * f1_dx_r);
      f2_dysq_r <= SQ_W'(f1_dy_r * f1_dy_r);
      f2_x_r    <= x_pre;
      f2_y_r    <= y_pre;
      f2_z_r    <= z_pre;
      f2_zero_r <= (f1_dx_r == '0) && (f1_dy_r == '0);
      f2_hd_r   <= f1_hd_r;
    end
  end

  // front stage 3: sum of squares, arrival test, chain entry
  logic            f3_vld_r;
  cell_data_t      f3_data_r;
  logic [SQ_W-1:0] sq;

  assign sq = f2_dxsq_r + f2_dysq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_vld_r <= 1'b0;
    end else if (f3_rdy) begin
      f3_vld_r <= f2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f3_rdy && f2_vld_r) begin
      f3_data_r.x        <= f2_x_r;
      f3_data_r.y        <= f2_y_r;
      f3_data_r.z        <= f2_z_r;
      f3_data_r.rem      <= sq;
      f3_data_r.root     <= '0;
      f3_data_r.heading  <= f2_hd_r;
      f3_data_r.zero_vec <= f2_zero_r;
      f3_data_r.arrived  <= sq < SQ_W'(tol_sq_r);
    end
  end

  // chain of cells
  logic       c_vld [CHAIN_LEN+1];
  logic       c_rdy [CHAIN_LEN+1];
  cell_data_t c_data[CHAIN_LEN+1];
  logic       b1_rdy;

  assign c_vld[0]  = f3_vld_r;
  assign c_data[0] = f3_data_r;
  assign f3_rdy    = c_rdy[0];
  assign c_rdy[CHAIN_LEN] = b1_rdy;

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_cell
    gtg_cell #(
      .IDX           (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_vld[k]),
      .up_data  (c_data[k]),
      .up_ready (c_rdy[k]),
      .dn_valid (c_vld[k+1]),
      .dn_data  (c_data[k+1]),
      .dn_ready (c_rdy[k+1])
    );
  end

  // back stage 1: bearing, wrapped heading error, linear product
  cell_data_t              tail;
  logic signed [Z_W-1:0]   z_rnd;
  logic signed [ERR_W-1:0] bear;
  logic signed [ERR_W-1:0] err0;
  logic signed [ERR_W-1:0] err_wr;
  logic                    b1_vld_r;
  logic signed [ERR_W-1:0] b1_err_r;
  logic [LINP_W-1:0]       b1_linp_r;
  logic                    b1_arr_r;
  logic                    b2_rdy;

  assign tail  = c_data[CHAIN_LEN];
  assign z_rnd = (tail.z + Z_RND) >>> Z_SHIFT;
  assign bear  = tail.zero_vec ? '0 : z_rnd[ERR_W-1:0];
  assign err0  = bear - ERR_W'(tail.heading);

  always_comb begin
    err_wr = err0;
    if (err0 > ANGLE_PI) begin
      err_wr = err0 - ANGLE_TWO_PI;
    end else if (err0 < -ANGLE_PI) begin
      err_wr = err0 + ANGLE_TWO_PI;
    end
  end

  assign b1_rdy = !b1_vld_r || b2_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (b1_rdy) begin
      b1_vld_r <= c_vld[CHAIN_LEN];
    end
  end

  always_ff @(posedge clk) begin
    if (b1_rdy && c_vld[CHAIN_LEN]) begin
      b1_err_r  <= err_wr;
      b1_linp_r <= tail.root[ROOT_W-1:0] * lin_gain_r;
      b1_arr_r  <= tail.arrived;
    end
  end

  // back stage 2: angular product, linear rounding and clamps
  logic [LINP_W:0]           lin_sum;
  logic [LINQ_W-1:0]         lin_q;
  logic [LINQ_W-1:0]         lin_lo;
  logic [LINQ_W-1:0]         lin_cl;
  logic                      b2_vld_r;
  logic signed [ANGP_W-1:0]  b2_angp_r;
  logic [SPD_W-1:0]          b2_lin_r;
  logic                      b2_arr_r;
  logic                      b3_rdy;

  assign lin_sum = {1'b0, b1_linp_r} + LIN_RND;
  assign lin_q   = lin_sum[LINP_W:LIN_SHIFT];

  always_comb begin
    lin_lo = (lin_q < LINQ_W'(min_spd_r)) ? LINQ_W'(min_spd_r) : lin_q;
    lin_cl = (lin_lo > LINQ_W'(max_spd_r)) ? LINQ_W'(max_spd_r) : lin_lo;
  end

  assign b2_rdy = !b2_vld_r || b3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_vld_r <= 1'b0;
    end else if (b2_rdy) begin
      b2_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_rdy && b1_vld_r) begin
      b2_angp_r <= ANGP_W'(b1_err_r) * $signed({1'b0, ang_gain_r});
      b2_lin_r  <= lin_cl[SPD_W-1:0];
      b2_arr_r  <= b1_arr_r;
    end
  end

  // back stage 3: angular rounding and clamp
  logic signed [ANGP_W-1:0] ang_q;
  logic signed [ANGP_W-1:0] ang_cl;
  logic                     b3_vld_r;
  logic [SPD_W-1:0]         b3_lin_r;
  logic signed [ANG_W-1:0]  b3_ang_r;
  logic                     b3_arr_r;
  logic                     out_load;

  assign ang_q = (b2_angp_r + ANG_RND) >>> ANG_SHIFT;

  always_comb begin
    ang_cl = ang_q;
    if (ang_q > ANG_LIMIT) begin
      ang_cl = ANG_LIMIT;
    end else if (ang_q < -ANG_LIMIT) begin
      ang_cl = -ANG_LIMIT;
    end
  end

  assign b3_rdy = !b3_vld_r || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_vld_r <= 1'b0;
    end else if (b3_rdy) begin
      b3_vld_r <= b2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b3_rdy && b2_vld_r) begin
      b3_lin_r <= b2_lin_r;
      b3_ang_r <= ang_cl[ANG_W-1:0];
      b3_arr_r <= b2_arr_r;
    end
  end

  // result register, stop item follows an arriving item
  logic                    out_valid_r;
  logic                    stop_pend_r;
  logic [SPD_W-1:0]        out_lin_r;
  logic signed [ANG_W-1:0] out_ang_r;
  logic                    out_arr_r;
  logic                    out_last_r;

  assign out_load = !out_valid_r || (out_ready && !stop_pend_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      stop_pend_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= b3_vld_r;
      stop_pend_r <= b3_vld_r && b3_arr_r;
    end else if (out_ready) begin
      stop_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && b3_vld_r) begin
      out_lin_r  <= b3_lin_r;
      out_ang_r  <= b3_ang_r;
      out_arr_r  <= 1'b0;
      out_last_r <= !b3_arr_r;
    end else if (out_valid_r && out_ready && stop_pend_r) begin
      out_lin_r  <= '0;
      out_ang_r  <= '0;
      out_arr_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_linear_speed  = out_lin_r;
  assign out_angular_speed = out_ang_r;
  assign out_arrived       = out_arr_r;
  assign out_last          = out_last_r;

endmodule

@@ hw/rtl/gtg_checker.sv @@
// gtg_checker: port-level assertions for the go-to-goal controller and the bind
// that attaches them; depends on gtg_pkg and go_to_goal_p_controller_unit
module gtg_checker import gtg_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SPD_W-1:0]        out_linear_speed,
  input logic signed [ANG_W-1:0] out_angular_speed,
  input logic                    out_arrived,
  input logic                    out_last
);

  // stop item is last and carries a zero command
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arrived |-> out_last && out_linear_speed == '0 &&
      out_angular_speed == '0)
    else $error("stop item not a zero last command");

  // a non-last result is followed at once by the stop item
  a_stop_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_arrived)
    else $error("stop item missing after non-last result");

  // turn rate stays within the clamp
  a_ang_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_angular_speed <= 16'sd24576 && out_angular_speed >= -16'sd24576)
    else $error("angular speed beyond clamp");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_linear_speed) &&
      $stable(out_angular_speed) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind go_to_goal_p_controller_unit gtg_checker u_gtg_checker (.*);
